### hdl/character_canvas_rect_fill_core_assert.svh
// Assertion macros for the character canvas rectangle fill core.
`ifndef CHARACTER_CANVAS_RECT_FILL_CORE_ASSERT_SVH
`define CHARACTER_CANVAS_RECT_FILL_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication under reset.
`define CCRF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccrf: same-cycle check failed");
// Next-cycle implication under reset.
`define CCRF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccrf: next-cycle check failed");
`else
`define CCRF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CCRF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/ccrf_pkg.sv
// Shared constants, types and a function of the character canvas fill core.
package ccrf_pkg;

    // Canvas geometry
    localparam int ROWS   = 32;
    localparam int COLS   = 64;
    localparam int DEPTH  = ROWS * COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_CW = $clog2(ROWS + 1);
    localparam int COL_CW = $clog2(COLS + 1);

    // Word field widths
    localparam int FUNC_W     = 2;
    localparam int BOX_W      = 9;
    localparam int CLIP_W     = BOX_W + 2;
    localparam int READ_ROW_W = 5;
    localparam int READ_COL_W = 6;
    localparam int CHAR_W     = 7;
    localparam int CODE_W     = 3;

    // Grid line spacing
    localparam int GRID_STEP = 5;
    localparam int MOD_W     = $clog2(GRID_STEP);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_FILL  = 2'd1,
        FUNC_READ  = 2'd2
    } t_func;

    typedef enum logic [CODE_W-1:0] {
        CODE_SPACE = 3'd0,
        CODE_PLUS  = 3'd1,
        CODE_DASH  = 3'd2,
        CODE_BAR   = 3'd3,
        CODE_STAR  = 3'd4
    } t_code;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_FILL,
        ST_READ,
        ST_DONE
    } t_state;

    // Map a stored cell code to its ASCII character
    function automatic logic [CHAR_W-1:0] code_to_ascii(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            CODE_SPACE: ch = 7'h20;
            CODE_PLUS:  ch = 7'h2B;
            CODE_DASH:  ch = 7'h2D;
            CODE_BAR:   ch = 7'h7C;
            CODE_STAR:  ch = 7'h2A;
            default:    ch = '0;
        endcase
        return ch;
    endfunction

endpackage

### hdl/ccrf_in_if.sv
// Input channel of the canvas core: one command word with valid and ready.
interface ccrf_in_if;
    import ccrf_pkg::*;

    logic                         valid;
    logic                         ready;
    logic        [FUNC_W-1:0]     func;
    logic signed [BOX_W-1:0]      box_x;
    logic signed [BOX_W-1:0]      box_y;
    logic signed [BOX_W-1:0]      box_width;
    logic signed [BOX_W-1:0]      box_height;
    logic        [READ_ROW_W-1:0] read_row;
    logic        [READ_COL_W-1:0] read_col;

    modport source (
        output valid, func, box_x, box_y, box_width, box_height, read_row, read_col,
        input  ready
    );
    modport sink (
        input  valid, func, box_x, box_y, box_width, box_height, read_row, read_col,
        output ready
    );
endinterface

### hdl/ccrf_out_if.sv
// Output channel of the canvas core: one result word with valid and ready.
interface ccrf_out_if;
    import ccrf_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] cell_char;

    modport source (
        output valid, cell_char,
        input  ready
    );
    modport sink (
        input  valid, cell_char,
        output ready
    );
endinterface

### hdl/ccrf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ccrf_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 2048
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, register one read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/character_canvas_rect_fill_core.sv
// Character canvas core: grid clear, clipped rectangle fill and cell read over one RAM.
// The canvas of ROWS by COLS cells lives in a single RAM with one write and one
// registered read port, so every write-back moves exactly one cell per cycle. After
// reset the core runs a sweep over all ROWS*COLS cells that draws the grid pattern and
// takes no command word meanwhile. A clear word repeats that sweep, then gives its
// result. A fill word stars each clipped cell of the box, or goes straight to its
// result when the clipped box is empty. A read word sends its address straight to
// the RAM, whose registered data gives the result. Commands are worked one at a time;
// a finished result waits in the output register while the next word is taken in.
`include "character_canvas_rect_fill_core_assert.svh"

module character_canvas_rect_fill_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ccrf_in_if.sink   i_in,
    ccrf_out_if.source o_out
);
    import ccrf_pkg::*;

    localparam logic signed [CLIP_W-1:0] COLS_S = CLIP_W'(COLS);
    localparam logic signed [CLIP_W-1:0] ROWS_S = CLIP_W'(ROWS);

    t_state              r_state, n_state;
    logic [ROW_CW-1:0]   r_row, n_row;
    logic [COL_CW-1:0]   r_col, n_col;
    logic [ROW_CW-1:0]   r_row_end, n_row_end;
    logic [COL_CW-1:0]   r_col_start, n_col_start;
    logic [COL_CW-1:0]   r_col_end, n_col_end;
    logic [MOD_W-1:0]    r_rmod, n_rmod;
    logic [MOD_W-1:0]    r_cmod, n_cmod;
    logic                r_sweep_res, n_sweep_res;
    logic                r_rd_ok, n_rd_ok;
    logic [CHAR_W-1:0]   r_res, n_res;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_out_char, n_out_char;

    logic                in_acc;
    logic                slot_free;
    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic [CODE_W-1:0]   w_wdata;
    logic [ADDR_W-1:0]   w_raddr;
    logic [CODE_W-1:0]   w_rdata;
    logic                rd_in_range;

    logic signed [CLIP_W-1:0] cx, cy, cw, ch, cx_end, cy_end;
    logic                     fill_empty;

    // Canvas storage
    ccrf_ram #(
        .WIDTH (CODE_W),
        .DEPTH (DEPTH)
    ) u_canvas (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Handshake
    assign i_in.ready      = (r_state == ST_IDLE);
    assign in_acc          = i_in.valid && i_in.ready;
    assign slot_free       = !r_out_valid || o_out.ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.cell_char = r_out_char;

    // Read address straight from the word; range flag masks out-of-canvas reads
    assign w_raddr     = ADDR_W'(32'(i_in.read_row) * COLS + 32'(i_in.read_col));
    assign rd_in_range = (32'(i_in.read_row) < ROWS) && (32'(i_in.read_col) < COLS);

    // Write port: grid code while sweeping, star while filling
    assign w_we    = (r_state == ST_SWEEP) || (r_state == ST_FILL);
    assign w_waddr = ADDR_W'(32'(r_row) * COLS + 32'(r_col));
    always_comb begin
        if (r_state == ST_FILL) begin
            w_wdata = CODE_STAR;
        end else if (r_rmod == '0) begin
            w_wdata = (r_cmod == '0) ? CODE_PLUS : CODE_DASH;
        end else begin
            w_wdata = (r_cmod == '0) ? CODE_BAR : CODE_SPACE;
        end
    end

    // Clip the box against the near edges and bound it by the far edges
    always_comb begin
        cx = CLIP_W'(i_in.box_x);
        cy = CLIP_W'(i_in.box_y);
        cw = CLIP_W'(i_in.box_width);
        ch = CLIP_W'(i_in.box_height);
        if (cx < 0) begin
            cw = cw + cx;
            cx = '0;
        end
        if (cy < 0) begin
            ch = ch + cy;
            cy = '0;
        end
        cx_end = cx + cw;
        cy_end = cy + ch;
        if (cx_end > COLS_S) begin
            cx_end = COLS_S;
        end
        if (cy_end > ROWS_S) begin
            cy_end = ROWS_S;
        end
        fill_empty = (cw <= 0) || (ch <= 0) || (cx >= COLS_S) || (cy >= ROWS_S);
    end

    // State and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_row       <= '0;
            r_col       <= '0;
            r_rmod      <= '0;
            r_cmod      <= '0;
            r_sweep_res <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_rmod      <= n_rmod;
            r_cmod      <= n_cmod;
            r_sweep_res <= n_sweep_res;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_row_end   <= n_row_end;
        r_col_start <= n_col_start;
        r_col_end   <= n_col_end;
        r_rd_ok     <= n_rd_ok;
        r_res       <= n_res;
        r_out_char  <= n_out_char;
    end

    // Next state and sequencing
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_row_end   = r_row_end;
        n_col_start = r_col_start;
        n_col_end   = r_col_end;
        n_rmod      = r_rmod;
        n_cmod      = r_cmod;
        n_sweep_res = r_sweep_res;
        n_rd_ok     = r_rd_ok;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;

        // Drop the held result once taken
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_SWEEP: begin
                if (r_col == COL_CW'(COLS - 1)) begin
                    n_col  = '0;
                    n_cmod = '0;
                    n_row  = r_row + 1'b1;
                    n_rmod = (r_rmod == MOD_W'(GRID_STEP - 1)) ? '0 : r_rmod + 1'b1;
                    if (r_row == ROW_CW'(ROWS - 1)) begin
                        n_res   = '0;
                        n_state = r_sweep_res ? ST_DONE : ST_IDLE;
                    end
                end else begin
                    n_col  = r_col + 1'b1;
                    n_cmod = (r_cmod == MOD_W'(GRID_STEP - 1)) ? '0 : r_cmod + 1'b1;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in.func)
                        FUNC_CLEAR: begin
                            n_row       = '0;
                            n_col       = '0;
                            n_rmod      = '0;
                            n_cmod      = '0;
                            n_sweep_res = 1'b1;
                            n_state     = ST_SWEEP;
                        end
                        FUNC_FILL: begin
                            n_res = '0;
                            if (fill_empty) begin
                                n_state = ST_DONE;
                            end else begin
                                n_row       = cy[ROW_CW-1:0];
                                n_col       = cx[COL_CW-1:0];
                                n_col_start = cx[COL_CW-1:0];
                                n_col_end   = cx_end[COL_CW-1:0];
                                n_row_end   = cy_end[ROW_CW-1:0];
                                n_state     = ST_FILL;
                            end
                        end
                        FUNC_READ: begin
                            n_rd_ok = rd_in_range;
                            n_state = ST_READ;
                        end
                        default: begin
                            n_res   = '0;
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_FILL: begin
                if (r_col == r_col_end - 1'b1) begin
                    n_col = r_col_start;
                    n_row = r_row + 1'b1;
                    if (r_row == r_row_end - 1'b1) begin
                        n_state = ST_DONE;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            ST_READ: begin
                n_res   = r_rd_ok ? code_to_ascii(w_rdata) : '0;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Checks on the sequencer
    `CCRF_ASSERT_IMP(a_we_only_busy, i_clk, i_rst_n, w_we, (r_state == ST_SWEEP) || (r_state == ST_FILL))
    `CCRF_ASSERT_NXT(a_read_follows, i_clk, i_rst_n, in_acc && (i_in.func == FUNC_READ), r_state == ST_READ)
    `CCRF_ASSERT_IMP(a_fill_in_box, i_clk, i_rst_n, r_state == ST_FILL, (r_col < r_col_end) && (r_row < r_row_end))
    `CCRF_ASSERT_NXT(a_done_loads, i_clk, i_rst_n, (r_state == ST_DONE) && slot_free, r_out_valid && (r_state == ST_IDLE))

endmodule

### tb/tb.sv
// Testbench for the character canvas core: grid clear, clipped box fill and cell read.
`timescale 1ns / 1ps

module tb;
    import ccrf_pkg::*;

    localparam int                 CLK_HALF    = 4;
    localparam int                 RST_CYCLES  = 7;
    localparam int                 HOLD_CYCLES = 80;
    localparam int                 DRAIN_WAIT  = 16;
    localparam int                 CYCLE_LIMIT = 3000000;
    localparam int                 RAND_WORDS  = 258;
    localparam int                 QUIET_FROM  = 222;
    localparam logic [FUNC_W-1:0]  FUNC_NONE   = 2'd3;

    // ASCII of the five cell codes
    localparam logic [CHAR_W-1:0] ASC_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] ASC_PLUS  = 7'h2B;
    localparam logic [CHAR_W-1:0] ASC_DASH  = 7'h2D;
    localparam logic [CHAR_W-1:0] ASC_BAR   = 7'h7C;
    localparam logic [CHAR_W-1:0] ASC_STAR  = 7'h2A;

    logic i_clk;
    logic i_rst_n;

    ccrf_in_if  in_ch();
    ccrf_out_if out_ch();

    character_canvas_rect_fill_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Canvas image kept by the testbench
    t_code             canvas_img [DEPTH];
    logic [CHAR_W-1:0] exp_chars [$];
    int                err_cnt   = 0;
    int                cycle_cnt = 0;
    logic              idle_en   = 1'b0;
    logic              hold_req  = 1'b0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Redraw the grid pattern into the image
    function automatic void draw_grid_img();
        int r;
        int c;
        for (r = 0; r < ROWS; r++) begin
            for (c = 0; c < COLS; c++) begin
                if (r % GRID_STEP == 0) begin
                    canvas_img[r*COLS + c] = (c % GRID_STEP == 0) ? CODE_PLUS : CODE_DASH;
                end else begin
                    canvas_img[r*COLS + c] = (c % GRID_STEP == 0) ? CODE_BAR : CODE_SPACE;
                end
            end
        end
    endfunction

    // Clip the box to the canvas and star its cells
    function automatic void fill_box_img(int x, int y, int w, int h);
        int r;
        int c;
        int r_end;
        int c_end;
        if (x < 0) begin
            w = w + x;
            x = 0;
        end
        if (y < 0) begin
            h = h + y;
            y = 0;
        end
        if (w <= 0 || h <= 0) return;
        r_end = (y + h > ROWS) ? ROWS : y + h;
        c_end = (x + w > COLS) ? COLS : x + w;
        for (r = y; r < r_end; r++) begin
            for (c = x; c < c_end; c++) begin
                canvas_img[r*COLS + c] = CODE_STAR;
            end
        end
    endfunction

    function automatic logic [CHAR_W-1:0] code_char(t_code code);
        case (code)
            CODE_SPACE: return ASC_SPACE;
            CODE_PLUS:  return ASC_PLUS;
            CODE_DASH:  return ASC_DASH;
            CODE_BAR:   return ASC_BAR;
            CODE_STAR:  return ASC_STAR;
            default:    return '0;
        endcase
    endfunction

    // Apply one word to the image and return the character it reports
    function automatic logic [CHAR_W-1:0] apply_word(
        logic [FUNC_W-1:0] f, int x, int y, int w, int h, int r, int c);
        logic [CHAR_W-1:0] ch;
        ch = '0;
        case (f)
            FUNC_CLEAR: draw_grid_img();
            FUNC_FILL:  fill_box_img(x, y, w, h);
            FUNC_READ: begin
                if (r < ROWS && c < COLS) ch = code_char(canvas_img[r*COLS + c]);
            end
            default: ch = '0;
        endcase
        return ch;
    endfunction

    // Offer one word, wait for it to be taken, then record its character
    task automatic send_word(
        input logic [FUNC_W-1:0] f,
        input int                x,
        input int                y,
        input int                w,
        input int                h,
        input int                r,
        input int                c);
        logic signed [BOX_W-1:0]  xs;
        logic signed [BOX_W-1:0]  ys;
        logic signed [BOX_W-1:0]  ws;
        logic signed [BOX_W-1:0]  hs;
        logic [READ_ROW_W-1:0]    rs;
        logic [READ_COL_W-1:0]    cs;
        xs = BOX_W'(x);
        ys = BOX_W'(y);
        ws = BOX_W'(w);
        hs = BOX_W'(h);
        rs = READ_ROW_W'(r);
        cs = READ_COL_W'(c);
        in_ch.valid      <= 1'b1;
        in_ch.func       <= f;
        in_ch.box_x      <= xs;
        in_ch.box_y      <= ys;
        in_ch.box_width  <= ws;
        in_ch.box_height <= hs;
        in_ch.read_row   <= rs;
        in_ch.read_col   <= cs;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        exp_chars.push_back(apply_word(f, int'(xs), int'(ys), int'(ws), int'(hs),
                                       int'(rs), int'(cs)));
        // Drop valid for a random burst
        if (idle_en && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic send_read(input int r, input int c);
        send_word(FUNC_READ, $urandom, $urandom, $urandom, $urandom, r, c);
    endtask

    task automatic send_fill(input int x, input int y, input int w, input int h);
        send_word(FUNC_FILL, x, y, w, h, $urandom, $urandom);
    endtask

    // Pattern left by the reset sweep
    task automatic test_reset_pattern();
        send_read(0, 0);
        send_read(0, 1);
        send_read(1, 0);
        send_read(31, 63);
    endtask

    // Negative corners, empty sizes and far-edge clipping
    task automatic test_fill_clipping();
        send_fill(-3, -2, 6, 5);
        send_fill(60, 29, 20, 10);
        send_fill(10, 10, 0, 4);
        send_fill(12, 12, 3, -5);
        send_fill(-10, 20, 10, 3);
        send_fill(-256, -256, 255, 255);
        send_fill(255, 255, 255, 255);
        send_fill(-256, 0, -256, -256);
        send_read(0, 0);
        send_read(2, 2);
        send_read(29, 60);
        send_read(3, 3);
    endtask

    // Unused selector leaves the canvas alone
    task automatic test_unused_func();
        send_word(FUNC_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        send_read(1, 1);
    endtask

    // Full-canvas fill, then clear back to the grid
    task automatic test_full_fill_clear();
        send_fill(0, 0, 255, 255);
        send_read(31, 63);
        send_word(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        send_read(30, 60);
    endtask

    // Hold off the result side while reads keep coming
    task automatic test_output_backpressure();
        int n;
        idle_en  = 1'b0;
        hold_req = 1'b1;
        for (n = 0; n < 10; n++) send_read($urandom_range(0, ROWS-1), $urandom_range(0, COLS-1));
    endtask

    task automatic test_random_traffic();
        int n;
        int pick;
        for (n = 0; n < RAND_WORDS; n++) begin
            // Switch idling on and off in stretches; none near the end
            if (n >= QUIET_FROM) idle_en = 1'b0;
            else if (n % 30 == 0) idle_en = ($urandom_range(0, 2) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                send_word(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom);
            end else if (pick < 7) begin
                send_word(FUNC_NONE, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom);
            end else if (pick < 10) begin
                send_word(FUNC_FILL, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom);
            end else if (pick < 40) begin
                send_fill($urandom_range(0, 80) - 10, $urandom_range(0, 44) - 6,
                          $urandom_range(0, 20) - 3, $urandom_range(0, 20) - 3);
            end else begin
                send_read($urandom_range(0, ROWS-1), $urandom_range(0, COLS-1));
            end
        end
    endtask

    // Result side: random stalls, long hold-off on request
    initial begin
        int stall_cnt;
        stall_cnt = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                stall_cnt = HOLD_CYCLES;
                hold_req  = 1'b0;
            end else if (stall_cnt == 0 && idle_en && $urandom_range(0, 5) == 0) begin
                stall_cnt = $urandom_range(1, 14);
            end
            if (stall_cnt > 0) begin
                out_ch.ready <= 1'b0;
                stall_cnt--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Compare each result word with the oldest expected character
    always @(posedge i_clk) begin
        logic [CHAR_W-1:0] want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (exp_chars.size() == 0) begin
                $error("cell_char: expected none, actual %0h", out_ch.cell_char);
                err_cnt++;
            end else begin
                want = exp_chars.pop_front();
                if (out_ch.cell_char !== want) begin
                    $error("cell_char: expected %0h, actual %0h", want, out_ch.cell_char);
                    err_cnt++;
                end
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.func       <= FUNC_CLEAR;
        in_ch.box_x      <= '0;
        in_ch.box_y      <= '0;
        in_ch.box_width  <= '0;
        in_ch.box_height <= '0;
        in_ch.read_row   <= '0;
        in_ch.read_col   <= '0;
        draw_grid_img();
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_en = 1'b1;

        test_reset_pattern();
        test_fill_clipping();
        test_unused_func();
        test_full_fill_clear();
        test_output_backpressure();
        test_random_traffic();

        // Drain outstanding results
        in_ch.valid <= 1'b0;
        while (exp_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/ccrf_pkg.sv
hdl/ccrf_in_if.sv
hdl/ccrf_out_if.sv
hdl/ccrf_ram.sv
hdl/character_canvas_rect_fill_core.sv
tb/tb.sv
